// ===== sv/aes_pkg.sv =====
// Package with the AES-128 types, constants and byte-level functions.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int CfgIdxWidth = 1;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY_UPPER = 1'b0;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY_LOWER = 1'b1;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   // Payload carried from one round cell to the next.
   typedef struct packed {
      logic      valid;
      block_type state;
      block_type key;
   } stage_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   // Round constant for rounds one to ten.
   function automatic byte_type rcon(input logic [3:0] rnd);
      byte_type r;
      case (rnd)
         4'd1: r = 8'h01;
         4'd2: r = 8'h02;
         4'd3: r = 8'h04;
         4'd4: r = 8'h08;
         4'd5: r = 8'h10;
         4'd6: r = 8'h20;
         4'd7: r = 8'h40;
         4'd8: r = 8'h80;
         4'd9: r = 8'h1b;
         4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the block sits in bits 127-8i down to 120-8i.
   function automatic byte_type get_byte(input block_type blk, input int i);
      return blk[127 - 8*i -: 8];
   endfunction

endpackage

// ===== sv/aes_round_cell.sv =====
// Combinational datapath of one round: a full or final AES round plus its key schedule step.
`timescale 1ns / 1ps
module aes_round_cell (
   input  logic [3:0]         round_num,
   input  aes_pkg::stage_type stage_in,
   output aes_pkg::stage_type stage_next
);
   import aes_pkg::*;

   localparam logic [3:0] RoundLast = 4'(NumRounds);

   block_type shifted;
   block_type mixed;
   block_type next_key;
   logic [31:0] temp_word;

   // SubBytes and ShiftRows: byte r+4c takes byte r+4((c+r) mod 4).
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shifted[127 - 8*(r + 4*c) -: 8] =
               sbox(get_byte(stage_in.state, r + 4*((c + r) % 4)));
         end
      end
   end

   // MixColumns, skipped in the last round.
   always_comb begin
      byte_type a0, a1, a2, a3, all;
      mixed = shifted;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(shifted, 4*c);
         a1 = get_byte(shifted, 4*c + 1);
         a2 = get_byte(shifted, 4*c + 2);
         a3 = get_byte(shifted, 4*c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         mixed[127 - 32*c -: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
         mixed[119 - 32*c -: 8]      = a1 ^ all ^ xtime(a1 ^ a2);
         mixed[111 - 32*c -: 8]      = a2 ^ all ^ xtime(a2 ^ a3);
         mixed[103 - 32*c -: 8]      = a3 ^ all ^ xtime(a3 ^ a0);
      end
   end

   // Key schedule step for this round.
   always_comb begin
      temp_word = {sbox(stage_in.key[23:16]) ^ rcon(round_num), sbox(stage_in.key[15:8]),
                   sbox(stage_in.key[7:0]), sbox(stage_in.key[31:24])};
      next_key[127:96] = stage_in.key[127:96] ^ temp_word;
      next_key[95:64]  = stage_in.key[95:64] ^ next_key[127:96];
      next_key[63:32]  = stage_in.key[63:32] ^ next_key[95:64];
      next_key[31:0]   = stage_in.key[31:0] ^ next_key[63:32];
   end

   // AddRoundKey with the new round key.
   always_comb begin
      stage_next.valid = stage_in.valid;
      stage_next.key   = next_key;
      stage_next.state = ((round_num == RoundLast) ? shifted : mixed) ^ next_key;
   end
endmodule

// ===== sv/aes_cell.sv =====
// One round cell: a full or final AES round plus the matching key schedule step.
`timescale 1ns / 1ps
module aes_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [3:0]         round_num,
   input  aes_pkg::stage_type stage_in,
   output aes_pkg::stage_type stage_out
);
   import aes_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_c;

   // Round datapath feeding the cell register.
   aes_round_cell u_round (
      .round_num  (round_num),
      .stage_in   (stage_in),
      .stage_next (stage_in_c)
   );

   // Cell register moves whenever the chain advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_c.valid;
      end
      if (advance) begin
         stage_ff.state <= stage_in_c.state;
         stage_ff.key   <= stage_in_c.key;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ===== sv/aes128_block_encrypt_top.sv =====
// Top level of the AES-128 encryptor: key registers, entry stage and ten round cells.
//
//  channel | direction | payload
//  req_    | in        | tdata = plain_upper[63:0], plain_lower[127:64]
//  rsp_    | out       | tdata = cipher_upper[63:0], cipher_lower[127:64]
//  csr_    | in        | index 0 key_upper, 1 key_lower; data 64 bits
//
// The entry stage register is loaded with the initial AddRoundKey at the accepting
// edge, and each result then passes through the registers of the ten round cells in
// order before it is offered on rsp_.
// One request is accepted every cycle unless the chain holds; the chain of cells moves as one and holds
// whenever the last cell holds a result that the consumer has not taken.
// Reset clears the key registers to zero and all cell valid bits.
`timescale 1ns / 1ps
module aes128_block_encrypt_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // plain_upper [63:0], plain_lower [127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // cipher_upper [63:0], cipher_lower [127:64]
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [aes_pkg::CfgIdxWidth-1:0] csr_index,
   input  logic [63:0]   csr_data
);
   import aes_pkg::*;

   logic [63:0] key_upper_ff;
   logic [63:0] key_lower_ff;
   logic        advance;
   stage_type   entry_ff;
   stage_type   chain [NumRounds+1];

   assign advance    = !chain[NumRounds].valid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   // Key register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_KEY_UPPER: key_upper_ff <= csr_data;
            CFG_KEY_LOWER: key_lower_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Entry stage: initial AddRoundKey.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff.valid <= req_tvalid;
      end
      if (advance) begin
         entry_ff.key   <= {key_upper_ff, key_lower_ff};
         entry_ff.state <= {req_tdata[63:0], req_tdata[127:64]}
                           ^ {key_upper_ff, key_lower_ff};
      end
   end

   assign chain[0] = entry_ff;

   // Ten round cells in a row.
   for (genvar g = 1; g <= NumRounds; g++) begin : g_round
      aes_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_num (4'(g)),
         .stage_in  (chain[g-1]),
         .stage_out (chain[g])
      );
   end

   assign rsp_tvalid = chain[NumRounds].valid;
   assign rsp_tdata  = {chain[NumRounds].state[63:0], chain[NumRounds].state[127:64]};

   // A held result must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // The chain is ready for a request whenever the last cell is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");
   // An accepted request sets the entry stage valid.
   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> entry_ff.valid)
      else $error("accepted request lost");
endmodule
